>>> hw/rtl/rla_pkg.sv
package rla_pkg;

	// Widths fixed by the item format
	localparam int VAL_W = 63;
	localparam int RES_W = 3;
	localparam int OP_W  = 2;
	localparam int ST_W  = 3;

	// Default table depth
	localparam int NUM_RESOURCES_DEF = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_RESERVE   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE   = 2'd1;
	localparam logic [OP_W-1:0] OP_SET_LIMIT = 2'd2;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_DENIED   = 3'd1;
	localparam logic [ST_W-1:0] ST_WAIT     = 3'd2;
	localparam logic [ST_W-1:0] ST_INVALID  = 3'd3;
	localparam logic [ST_W-1:0] ST_RELERR   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [RES_W-1:0] resource;
		logic [VAL_W-1:0] amount;
		logic [VAL_W-1:0] release_hint;
		logic             wait_allowed;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] limit_value;
		logic [VAL_W-1:0] current_value;
		logic [VAL_W-1:0] peak_value;
		logic [VAL_W-1:0] free_value;
	} rsp_t;

	// One accounting row of a resource
	typedef struct packed {
		logic [VAL_W-1:0] limit;
		logic [VAL_W-1:0] current;
		logic [VAL_W-1:0] hint;
		logic [VAL_W-1:0] peak;
	} row_t;

endpackage

>>> hw/rtl/rla_table.sv
module rla_table #(
	parameter int NUM_RESOURCES = rla_pkg::NUM_RESOURCES_DEF,
	parameter int IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] idx,
	input  rla_pkg::row_t    wr_row,
	output rla_pkg::row_t    rd_row
);
	import rla_pkg::*;

	row_t rows_q [NUM_RESOURCES];

	// Row storage, cleared by reset, written in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (wr_en) begin
			rows_q[idx] <= wr_row;
		end
	end

	assign rd_row = rows_q[idx];

endmodule

>>> hw/rtl/rla_update.sv
module rla_update (
	input  rla_pkg::req_t req,
	input  logic          in_range,
	input  rla_pkg::row_t row,
	output logic          wr_en,
	output rla_pkg::row_t new_row,
	output rla_pkg::rsp_t rsp
);
	import rla_pkg::*;

	logic [VAL_W:0]   sum;
	logic [VAL_W:0]   hsum;
	logic [VAL_W-1:0] diff;
	logic [ST_W-1:0]  status;

	// Reserve sums, one bit wider to catch overflow
	assign sum  = {1'b0, row.current} + {1'b0, req.amount};
	assign hsum = {1'b0, row.hint} + {1'b0, req.amount};

	// Operation decode and row update
	always_comb begin
		logic [ST_W-1:0] st;
		row_t            nr;
		logic            we;
		nr = row;
		we = 1'b0;
		st = ST_INVALID;
		unique case (req.operation)
			OP_RESERVE: begin
				if (row.hint >= row.limit) begin
					st = ST_DENIED;
				end else if (req.amount == '0 || sum[VAL_W]) begin
					st = ST_DENIED;
				end else if (sum <= {1'b0, row.limit}) begin
					st = ST_OK;
					we = 1'b1;
					nr.current = sum[VAL_W-1:0];
					nr.hint    = hsum[VAL_W-1:0];
					if (sum[VAL_W-1:0] > row.peak) begin
						nr.peak = sum[VAL_W-1:0];
					end
				end else if (hsum <= {1'b0, row.limit} && req.wait_allowed) begin
					st = ST_WAIT;
				end else begin
					st = ST_DENIED;
				end
			end
			OP_RELEASE: begin
				if (req.amount > row.current || req.release_hint > row.hint) begin
					st = ST_RELERR;
				end else begin
					st = ST_OK;
					we = 1'b1;
					nr.current = row.current - req.amount;
					nr.hint    = row.hint - req.release_hint;
				end
			end
			OP_SET_LIMIT: begin
				if (row.current > req.amount) begin
					st = ST_INVALID;
				end else begin
					st = ST_OK;
					we = 1'b1;
					nr.limit = req.amount;
					nr.peak  = row.current;
				end
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
		new_row = nr;
		wr_en   = we && in_range;
		status  = in_range ? st : ST_INVALID;
	end

	assign diff = new_row.limit - new_row.current;

	// Result fields; an out-of-range index reports zeros
	always_comb begin
		rsp.status = status;
		if (in_range) begin
			rsp.limit_value   = new_row.limit;
			rsp.current_value = new_row.current;
			rsp.peak_value    = new_row.peak;
			rsp.free_value    = (new_row.limit >= new_row.current) ? diff : '0;
		end else begin
			rsp.limit_value   = '0;
			rsp.current_value = '0;
			rsp.peak_value    = '0;
			rsp.free_value    = '0;
		end
	end

endmodule

>>> hw/rtl/resource_limit_accounting_core.sv
// Channel  | Handshake     | Payload        | Transfer
// ---------+---------------+----------------+----------------------------------
// command  | start / busy  | req  (req_t)   | edge with start high, busy low
// result   | done          | rsp  (rsp_t)   | edge ending the cycle done is high
//
// One command per cycle; busy never rises, the row table is in the data path.
// Each command passes the input register, then a table read-modify-write into the
// result register. The next command sees the rows written by the previous one.
// arst_n clears all rows to zero and drops any command in flight.
// The receiver cannot stall; each result shows for exactly one cycle.
module resource_limit_accounting_core #(
	parameter int NUM_RESOURCES = rla_pkg::NUM_RESOURCES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rla_pkg::req_t req,
	output logic          done,
	output rla_pkg::rsp_t rsp
);
	import rla_pkg::*;

	localparam int IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

	logic             valid_s1;
	req_t             req_s1;
	logic             done_s2;
	rsp_t             rsp_s2;
	logic             in_range;
	logic [IDX_W-1:0] idx;
	logic             wr_en;
	row_t             rd_row;
	row_t             wr_row;
	rsp_t             rsp_next;

	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// Index decode
	assign in_range = (32'(req_s1.resource) < NUM_RESOURCES);
	assign idx      = IDX_W'(req_s1.resource);

	rla_table #(
		.NUM_RESOURCES(NUM_RESOURCES),
		.IDX_W        (IDX_W)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (wr_en && valid_s1),
		.idx   (idx),
		.wr_row(wr_row),
		.rd_row(rd_row)
	);

	rla_update u_update (
		.req     (req_s1),
		.in_range(in_range),
		.row     (rd_row),
		.wr_en   (wr_en),
		.new_row (wr_row),
		.rsp     (rsp_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign done = done_s2;
	assign rsp  = rsp_s2;

endmodule

>>> hw/rtl/rla_checker.sv
module rla_checker #(
	parameter int NUM_RESOURCES = rla_pkg::NUM_RESOURCES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input rla_pkg::req_t req,
	input logic          done,
	input rla_pkg::rsp_t rsp
);
	import rla_pkg::*;

	// Every accepted command yields a result through the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted command produced no result");

	// No result without a command
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted command");

	// An out-of-range resource reports invalid_state and zero values
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (32'(req.resource) >= NUM_RESOURCES) |-> ##2
		(rsp.status == ST_INVALID && rsp.limit_value == '0 &&
		 rsp.current_value == '0 && rsp.peak_value == '0))
		else $error("out-of-range access reported values");

	// Current never exceeds limit, free is their difference
	a_free_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.current_value <= rsp.limit_value &&
		rsp.free_value == rsp.limit_value - rsp.current_value))
		else $error("free amount inconsistent with limit and current");

	// Peak never below current
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.peak_value >= rsp.current_value)
		else $error("peak below current amount");

endmodule

bind resource_limit_accounting_core rla_checker #(
	.NUM_RESOURCES(NUM_RESOURCES)
) u_rla_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);
